// ===== hdl/i2c_slave_eeprom_emulator_macros.svh =====
// ----------------------------------------------------------------------------
// I2C EEPROM emulator assertion macros
// Shorthand for clocked properties, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef I2C_SLAVE_EEPROM_EMULATOR_MACROS_SVH
`define I2C_SLAVE_EEPROM_EMULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CEE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/i2cee_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM emulator package
// Status codes, transfer modes and register constants of the emulator.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    // Input beat kinds.
    localparam logic OP_BUS_EVENT = 1'b0;
    localparam logic OP_TICK      = 1'b1;

    // I2C slave status codes.
    localparam logic [7:0] SC_ADDR_WRITE     = 8'h60;
    localparam logic [7:0] SC_ADDR_WRITE_ARB = 8'h68;
    localparam logic [7:0] SC_DATA_RX        = 8'h80;
    localparam logic [7:0] SC_DATA_RX_GEN    = 8'h88;
    localparam logic [7:0] SC_READ_START     = 8'hA8;
    localparam logic [7:0] SC_READ_CONT      = 8'hB8;
    localparam logic [7:0] SC_STOP           = 8'hC0;
    localparam logic [7:0] SC_RESTART        = 8'hA0;

    // Transfer modes.
    typedef logic [2:0] mode_t;
    localparam mode_t MODE_IDLE    = 3'd0;
    localparam mode_t MODE_ADDR_HI = 3'd1;
    localparam mode_t MODE_ADDR_LO = 3'd2;
    localparam mode_t MODE_DATA    = 3'd3;
    localparam mode_t MODE_READ    = 3'd4;

    // Configuration register.
    localparam logic [7:0] TIMEOUT_RESET   = 8'd20;
    localparam logic       REG_IDX_TIMEOUT = 1'b0;

endpackage

// ===== hdl/i2c_slave_eeprom_emulator.sv =====
// ----------------------------------------------------------------------------
// I2C slave EEPROM emulator
// Back end of an I2C slave that behaves like a 24C64-style serial EEPROM,
// with a byte store in a synchronous memory and a bus timeout recovery.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_*       in         tuser: opcode; tdata: status_code, rx_byte
//  m_*       out        tuser: tx_valid, recovered; tdata: tx_byte
//  APB       in/out     timeout_ticks at byte address 0
//
// After reset a clearing pass writes zeros to all STORE_DEPTH entries of the
// store, one entry per cycle; no beat is taken during it.
// A read event is answered from ST_READ, where no beat is taken, once the
// store's registered read port returns its byte; others answer at once.
// A result waiting on m_* holds s_tready low until it is taken or is taken
// in the same cycle.
// ----------------------------------------------------------------------------
`include "i2c_slave_eeprom_emulator_macros.svh"

module i2c_slave_eeprom_emulator
    import i2cee_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [7:0] status_code, [15:8] rx_byte
    input  logic        s_tuser,     // [0] opcode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] tx_byte
    output logic [1:0]  m_tuser,     // [0] tx_valid, [1] recovered

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    mode_t         mode_reg, mode_next;
    logic [15:0]   ptr_reg, ptr_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [7:0]    ticks_reg, ticks_next;

    logic          out_valid_reg, out_valid_next;
    logic          tx_valid_reg, tx_valid_next;
    logic [7:0]    tx_byte_reg, tx_byte_next;
    logic          recovered_reg, recovered_next;

    logic [7:0]    store_mem [STORE_DEPTH];
    logic [7:0]    mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    logic          accept;
    logic          opcode;
    logic [7:0]    status_code;
    logic [7:0]    rx_byte;
    logic          ptr_in_range;
    logic [15:0]   ptr_eff;
    logic [AW-1:0] ptr_idx;
    logic [15:0]   ptr_inc;
    logic [7:0]    cnt_dec;
    logic          recover_now;
    logic          cfg_write;

    assign opcode      = s_tuser;
    assign status_code = s_tdata[7:0];
    assign rx_byte     = s_tdata[15:8];

    // A pointer at or beyond the store depth wraps to zero before access.
    assign ptr_in_range = ({1'b0, ptr_reg} < 17'(STORE_DEPTH));
    assign ptr_eff      = ptr_in_range ? ptr_reg : 16'd0;
    assign ptr_idx      = ptr_eff[AW-1:0];
    assign ptr_inc      = ptr_eff + 16'd1;

    assign cnt_dec     = (cnt_reg != 8'd0) ? (cnt_reg - 8'd1) : 8'd0;
    assign recover_now = (cnt_dec == 8'd0) && (mode_reg != MODE_IDLE);

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tx_byte_reg;
    assign m_tuser  = {recovered_reg, tx_valid_reg};

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_IDX_TIMEOUT);
    assign ticks_next = cfg_write ? pwdata[7:0] : ticks_reg;
    assign prdata     = (paddr[2] == REG_IDX_TIMEOUT) ? {24'd0, ticks_reg} : 32'd0;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        mode_next      = mode_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        tx_valid_next  = tx_valid_reg;
        tx_byte_next   = tx_byte_reg;
        recovered_next = recovered_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_cnt_reg;
        mem_wdata      = 8'd0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_cnt_reg == AW'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    // Most beats answer at once; reads wait for the store.
                    out_valid_next = 1'b1;
                    tx_valid_next  = 1'b0;
                    tx_byte_next   = 8'd0;
                    recovered_next = 1'b0;
                    if (opcode == OP_TICK)
                    begin
                        cnt_next = cnt_dec;
                        if (recover_now)
                        begin
                            mode_next      = MODE_IDLE;
                            ptr_next       = 16'd0;
                            cnt_next       = ticks_reg;
                            recovered_next = 1'b1;
                        end
                    end
                    else
                    begin
                        case (status_code) inside
                            SC_ADDR_WRITE, SC_ADDR_WRITE_ARB:
                            begin
                                mode_next = MODE_ADDR_HI;
                                cnt_next  = ticks_reg;
                            end
                            SC_DATA_RX, SC_DATA_RX_GEN:
                            begin
                                cnt_next = ticks_reg;
                                case (mode_reg)
                                    MODE_ADDR_HI:
                                    begin
                                        mode_next = MODE_ADDR_LO;
                                        ptr_next  = {rx_byte, ptr_reg[7:0]};
                                    end
                                    MODE_ADDR_LO:
                                    begin
                                        mode_next = MODE_DATA;
                                        ptr_next  = {ptr_reg[15:8], rx_byte};
                                    end
                                    MODE_DATA:
                                    begin
                                        mem_we    = 1'b1;
                                        mem_waddr = ptr_idx;
                                        mem_wdata = rx_byte;
                                        ptr_next  = ptr_inc;
                                    end
                                    default:
                                    begin
                                        mode_next = mode_reg;
                                    end
                                endcase
                            end
                            SC_READ_START, SC_READ_CONT:
                            begin
                                if (status_code == SC_READ_START)
                                begin
                                    mode_next = MODE_READ;
                                end
                                ptr_next       = ptr_inc;
                                cnt_next       = ticks_reg;
                                out_valid_next = 1'b0;
                                state_next     = ST_READ;
                            end
                            SC_STOP, SC_RESTART:
                            begin
                                mode_next = MODE_IDLE;
                                cnt_next  = ticks_reg;
                            end
                            default:
                            begin
                                cnt_next = cnt_reg;
                            end
                        endcase
                    end
                end
            end

            ST_READ:
            begin
                // The read was issued at the accepting edge; the slot is free.
                out_valid_next = 1'b1;
                tx_valid_next  = 1'b1;
                tx_byte_next   = mem_rdata_reg;
                recovered_next = 1'b0;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            mode_reg      <= MODE_IDLE;
            ptr_reg       <= 16'd0;
            cnt_reg       <= TIMEOUT_RESET;
            ticks_reg     <= TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            mode_reg      <= mode_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            ticks_reg     <= ticks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_valid_reg  <= tx_valid_next;
        tx_byte_reg   <= tx_byte_next;
        recovered_reg <= recovered_next;
    end

    // Byte store, one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= store_mem[ptr_idx];
    end

    `I2CEE_ASSERT_SAME(a_no_beat_while_clearing, state_reg == ST_CLEAR, !s_tready,
        "input beat offered while the store is being cleared")
    `I2CEE_ASSERT_SAME(a_read_slot_free, state_reg == ST_READ, !out_valid_reg,
        "output slot occupied when read data returns")
    `I2CEE_ASSERT_SAME(a_flags_exclusive, out_valid_reg, !(tx_valid_reg && recovered_reg),
        "result marks both a sent byte and a recovery")
    `I2CEE_ASSERT_SAME(a_tx_byte_zero, out_valid_reg && !tx_valid_reg, tx_byte_reg == 8'd0,
        "result carries a byte without tx_valid")
    `I2CEE_ASSERT_NEXT(a_recover_clears,
        accept && (opcode == OP_TICK) && recover_now,
        (mode_reg == MODE_IDLE) && (ptr_reg == 16'd0),
        "timeout recovery left a transfer open")

endmodule
